/* hw/rtl/tal_pkg.sv */
// shared types and constants of the tree ancestor / lca engine
// used by tree_ancestor_lca_engine
package tal_pkg;
	localparam int NodeW   = 10;
	localparam int MaxNodes = 1024;
	localparam int Levels  = 10;
	localparam int LvlW    = 4;
	localparam int TabAw   = 14;
	localparam int TabDepth = MaxNodes * Levels;
	localparam int EntryW  = NodeW + 1;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_KTH    = 2'd1,
		CMD_LCA    = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_INS_RD,
		ST_INS_WR,
		ST_KTH_RD,
		ST_KTH_WT,
		ST_DEP_RD,
		ST_DEP_WT,
		ST_LIFT_RD,
		ST_LIFT_WT,
		ST_CMP_RD,
		ST_CMP_WT,
		ST_FIN_RD,
		ST_FIN_WT,
		ST_DONE
	} state_t;

	// table address of entry (node, level)
	function automatic logic [TabAw-1:0] tab_addr(input logic [NodeW-1:0] n,
			input logic [LvlW-1:0] l);
		logic [TabAw+3:0] p;
		p = {4'd0, n} * 18'(Levels) + 18'(l);
		return p[TabAw-1:0];
	endfunction
endpackage

/* hw/rtl/tal_ram.sv */
// generic single port ram with registered read
// no dependencies
module tal_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

/* hw/rtl/tree_ancestor_lca_engine.sv */
// binary lifting ancestor / lca engine: top level
// depends on tal_pkg and tal_ram
//
// After reset the block clears all 10240 jump table entries and the depth
// store (busy high). A request is taken when start is high and busy low.
// Every table access goes through one single port memory with registered
// read, so each table read takes a read state and a wait state. An insert
// reads a parent row level and writes its own row level for all ten levels.
// A k-th query reads one table level per set bit of step_count up to its top
// set bit, skipping clear bits, and stops early when the climb leaves the
// tree. An lca query does two depth reads, a lift, up to ten compare levels
// of two reads each and a final parent read. Each query gives one result
// pulse on done in the same cycle that busy falls; the receiver cannot stall it.
module tree_ancestor_lca_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [9:0]  node_a,
	input  logic [9:0]  node_b,
	input  logic [9:0]  parent_node,
	input  logic        parent_present,
	input  logic [9:0]  node_depth,
	input  logic [9:0]  step_count,
	output logic        done,
	output logic [9:0]  result_node,
	output logic        result_valid
);
	localparam int NW = tal_pkg::NodeW;
	localparam int LW = tal_pkg::LvlW;
	localparam int AW = tal_pkg::TabAw;
	localparam int EW = tal_pkg::EntryW;

	tal_pkg::state_t st_q, st_d;

	logic [AW-1:0] clr_q;
	logic [LW-1:0] lvl_q;
	logic [NW-1:0] k_q;
	logic          sel_b_q;
	logic [EW-1:0] ea_q, eb_q, e_q, ja_q;
	logic [NW-1:0] da_q;
	logic [NW-1:0] tgt_q;
	logic [NW-1:0] dep_q;
	logic [EW-1:0] res_q;
	logic          done_q;

	logic          t_we, d_we;
	logic [AW-1:0] t_addr;
	logic [EW-1:0] t_wdata, t_rdata;
	logic [NW-1:0] d_addr, d_wdata, d_rdata;

	tal_ram #(.Width(EW), .Depth(tal_pkg::TabDepth)) u_tab (
		.clk(clk), .we(t_we), .addr(t_addr), .wdata(t_wdata), .rdata(t_rdata));
	tal_ram #(.Width(NW), .Depth(tal_pkg::MaxNodes)) u_dep (
		.clk(clk), .we(d_we), .addr(d_addr), .wdata(d_wdata), .rdata(d_rdata));

	assign busy = (st_q != tal_pkg::ST_IDLE);
	logic accept;
	assign accept = start && !busy;
	logic clr_last;
	assign clr_last = (clr_q == AW'(tal_pkg::TabDepth - 1));

	// next set bit search of k at or above lvl
	logic          kbit;
	assign kbit = k_q[lvl_q];
	logic          k_rest;
	assign k_rest = ((k_q >> lvl_q) != '0);

	// first compare step, right after the lift
	logic          cmp_first;
	assign cmp_first = (lvl_q == LW'(tal_pkg::Levels - 1)) && !sel_b_q;

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			tal_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (tal_pkg::cmd_t'(command))
						tal_pkg::CMD_INSERT: st_d = tal_pkg::ST_INS_RD;
						tal_pkg::CMD_KTH:    st_d = tal_pkg::ST_KTH_RD;
						tal_pkg::CMD_LCA:    st_d = tal_pkg::ST_DEP_RD;
						tal_pkg::CMD_NOP:    st_d = tal_pkg::ST_IDLE;
					endcase
				end
			end
			tal_pkg::ST_CLEAR: if (clr_last) st_d = tal_pkg::ST_IDLE;
			tal_pkg::ST_INS_RD: st_d = tal_pkg::ST_INS_WR;
			tal_pkg::ST_INS_WR:
				st_d = (lvl_q == LW'(tal_pkg::Levels - 1)) ? tal_pkg::ST_IDLE
					: tal_pkg::ST_INS_RD;
			tal_pkg::ST_KTH_RD: begin
				if (!k_rest || !e_q[NW]) st_d = tal_pkg::ST_DONE;
				else if (kbit) st_d = tal_pkg::ST_KTH_WT;
			end
			tal_pkg::ST_KTH_WT: st_d = tal_pkg::ST_KTH_RD;
			tal_pkg::ST_DEP_RD: st_d = tal_pkg::ST_DEP_WT;
			tal_pkg::ST_DEP_WT: st_d = sel_b_q ? tal_pkg::ST_LIFT_RD : tal_pkg::ST_DEP_RD;
			tal_pkg::ST_LIFT_RD: begin
				if (!k_rest || !e_q[NW]) st_d = tal_pkg::ST_CMP_RD;
				else if (kbit) st_d = tal_pkg::ST_LIFT_WT;
			end
			tal_pkg::ST_LIFT_WT: st_d = tal_pkg::ST_LIFT_RD;
			tal_pkg::ST_CMP_RD: begin
				if (cmp_first && (!ea_q[NW] || !eb_q[NW] || ea_q == eb_q))
					st_d = tal_pkg::ST_DONE;
				else st_d = tal_pkg::ST_CMP_WT;
			end
			tal_pkg::ST_CMP_WT: begin
				if (sel_b_q && lvl_q == '0) st_d = tal_pkg::ST_FIN_RD;
				else st_d = tal_pkg::ST_CMP_RD;
			end
			tal_pkg::ST_FIN_RD: st_d = tal_pkg::ST_FIN_WT;
			tal_pkg::ST_FIN_WT: st_d = tal_pkg::ST_DONE;
			tal_pkg::ST_DONE: st_d = tal_pkg::ST_IDLE;
			default: st_d = tal_pkg::ST_IDLE;
		endcase
	end

	// memory port drive
	always_comb begin
		t_we = 1'b0;
		t_addr = tal_pkg::tab_addr(e_q[NW-1:0], lvl_q);
		t_wdata = '0;
		d_we = 1'b0;
		d_addr = ea_q[NW-1:0];
		d_wdata = dep_q;
		unique case (st_q)
			tal_pkg::ST_CLEAR: begin
				t_we = 1'b1;
				t_addr = clr_q;
				d_we = 1'b1;
				d_addr = clr_q[NW-1:0];
				d_wdata = '0;
			end
			tal_pkg::ST_INS_RD: t_addr = tal_pkg::tab_addr(e_q[NW-1:0], lvl_q - LW'(1));
			tal_pkg::ST_INS_WR: begin
				t_we = 1'b1;
				t_addr = tal_pkg::tab_addr(tgt_q, lvl_q);
				t_wdata = (lvl_q == '0) ? e_q : (e_q[NW] ? t_rdata : '0);
				d_we = (lvl_q == '0);
				d_addr = tgt_q;
			end
			tal_pkg::ST_DEP_RD: d_addr = sel_b_q ? eb_q[NW-1:0] : ea_q[NW-1:0];
			tal_pkg::ST_CMP_RD:
				t_addr = tal_pkg::tab_addr(sel_b_q ? eb_q[NW-1:0] : ea_q[NW-1:0], lvl_q);
			tal_pkg::ST_FIN_RD: t_addr = tal_pkg::tab_addr(ea_q[NW-1:0], '0);
			default: ;
		endcase
	end

	logic [NW-1:0] db_w;
	assign db_w = d_rdata;

	// ancestor of b at this level; none once b has left the tree
	logic [EW-1:0] jb_w;
	assign jb_w = eb_q[NW] ? t_rdata : '0;

	// registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= tal_pkg::ST_CLEAR;
			clr_q <= '0;
			done_q <= 1'b0;
		end else begin
			st_q <= st_d;
			done_q <= (st_q == tal_pkg::ST_DONE);
			if (st_q == tal_pkg::ST_CLEAR) clr_q <= clr_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			tal_pkg::ST_IDLE: begin
				tgt_q <= node_a;
				dep_q <= node_depth;
				ea_q <= {1'b1, node_a};
				eb_q <= {1'b1, node_b};
				k_q <= step_count;
				lvl_q <= '0;
				sel_b_q <= 1'b0;
				if (tal_pkg::cmd_t'(command) == tal_pkg::CMD_INSERT)
					e_q <= parent_present ? {1'b1, parent_node} : '0;
				else
					e_q <= {1'b1, node_a};
			end
			tal_pkg::ST_INS_WR: begin
				e_q <= t_wdata;
				lvl_q <= lvl_q + LW'(1);
			end
			tal_pkg::ST_KTH_RD, tal_pkg::ST_LIFT_RD: begin
				if (!k_rest || !e_q[NW]) begin
					res_q <= e_q;
					if (st_q == tal_pkg::ST_LIFT_RD) begin
						if (sel_b_q) eb_q <= e_q; else ea_q <= e_q;
						lvl_q <= LW'(tal_pkg::Levels - 1);
						sel_b_q <= 1'b0;
					end
				end else if (!kbit) lvl_q <= lvl_q + LW'(1);
			end
			tal_pkg::ST_KTH_WT, tal_pkg::ST_LIFT_WT: begin
				e_q <= t_rdata;
				lvl_q <= lvl_q + LW'(1);
			end
			tal_pkg::ST_DEP_WT: begin
				if (!sel_b_q) begin
					da_q <= d_rdata;
					sel_b_q <= 1'b1;
				end else begin
					lvl_q <= '0;
					// lift deeper node by depth difference
					if (da_q > db_w) begin
						k_q <= da_q - db_w;
						e_q <= ea_q;
						sel_b_q <= 1'b0;
					end else begin
						k_q <= db_w - da_q;
						e_q <= eb_q;
						sel_b_q <= 1'b1;
					end
				end
			end
			tal_pkg::ST_CMP_RD: begin
				res_q <= (!ea_q[NW] || !eb_q[NW]) ? '0 : ea_q;
			end
			tal_pkg::ST_CMP_WT: begin
				if (!sel_b_q) begin
					ja_q <= t_rdata;
					sel_b_q <= 1'b1;
				end else begin
					// move both when a's ancestor exists and differs from b's
					if (ja_q[NW] && ja_q != jb_w) begin
						ea_q <= ja_q;
						eb_q <= jb_w;
					end
					sel_b_q <= 1'b0;
					lvl_q <= lvl_q - LW'(1);
				end
			end
			tal_pkg::ST_FIN_WT: res_q <= t_rdata;
			default: ;
		endcase
	end

	assign done = done_q;
	assign result_valid = res_q[NW];
	assign result_node = res_q[NW] ? res_q[NW-1:0] : '0;

`ifndef NO_ASSERTIONS
	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");
	a_no_wr_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !t_we) else $error("table write while idle");
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == tal_pkg::ST_CLEAR) |-> busy) else $error("clear not busy");
`endif
endmodule
